// File: design/itoa_pkg.sv
// Shared types, constants, character mapping and microcode for the radix text converter.
`default_nettype none

package itoa_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;

  localparam int unsigned BASE_W = 6;
  localparam int unsigned REM_W  = 6;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned UPC_W  = 4;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LOWA  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  localparam logic [BASE_W-1:0] DEC_BASE = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  // Microprogram step addresses
  localparam logic [UPC_W-1:0] STEP_IDLE     = 4'd0;
  localparam logic [UPC_W-1:0] STEP_DIV_INIT = 4'd1;
  localparam logic [UPC_W-1:0] STEP_DIV_STEP = 4'd2;
  localparam logic [UPC_W-1:0] STEP_PUSH     = 4'd3;
  localparam logic [UPC_W-1:0] STEP_SIGN     = 4'd4;
  localparam logic [UPC_W-1:0] STEP_POP      = 4'd5;
  localparam logic [UPC_W-1:0] STEP_WAIT     = 4'd6;
  localparam logic [UPC_W-1:0] STEP_EMIT     = 4'd7;
  localparam logic [UPC_W-1:0] STEP_DONE     = 4'd8;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ACCEPT,
    COND_CNT_NZ,
    COND_QUOT_NZ,
    COND_OUT_BUSY,
    COND_SP_NZ
  } cond_e;

  typedef struct packed {
    logic             in_ready;
    logic             load;
    logic             div_init;
    logic             div_step;
    logic             push_digit;
    logic             push_minus;
    logic             pop_rd;
    logic             emit;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic cnt_nz;
    logic quot_nz;
    logic sp_nz;
  } dp_stat_t;

  typedef struct packed {
    logic     accept;
    logic     out_busy;
    dp_stat_t dp;
  } seq_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {{(CHAR_W-REM_W){1'b0}}, d};
    if (d < REM_W'(DEC_BASE)) begin
      return CH_ZERO + dx;
    end
    return CH_LOWA + dx - CHAR_W'(DEC_BASE);
  endfunction

  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] step);
    ctrl_t w;
    w = '{cond: COND_NEVER, target: STEP_IDLE, default: 1'b0};
    unique case (step)
      STEP_IDLE: begin
        w.in_ready = 1'b1;
        w.load     = 1'b1;
        w.cond     = COND_NO_ACCEPT;
        w.target   = STEP_IDLE;
      end
      STEP_DIV_INIT: begin
        w.div_init = 1'b1;
      end
      STEP_DIV_STEP: begin
        w.div_step = 1'b1;
        w.cond     = COND_CNT_NZ;
        w.target   = STEP_DIV_STEP;
      end
      STEP_PUSH: begin
        w.push_digit = 1'b1;
        w.cond       = COND_QUOT_NZ;
        w.target     = STEP_DIV_INIT;
      end
      STEP_SIGN: begin
        w.push_minus = 1'b1;
      end
      STEP_POP: begin
        w.pop_rd = 1'b1;
      end
      STEP_WAIT: begin
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_WAIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_SP_NZ;
        w.target = STEP_POP;
      end
      STEP_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: design/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module itoa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 33
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: design/itoa_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jump logic.
`default_nettype none

module itoa_seq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire itoa_pkg::seq_stat_t  stat_i,
  output itoa_pkg::ctrl_t           ctrl_o
);

  logic [itoa_pkg::UPC_W-1:0] upc_q, upc_d;
  itoa_pkg::ctrl_t            ctrl;
  logic                       taken;

  assign ctrl = itoa_pkg::ucode_rom(upc_q);

  always_comb begin
    unique case (ctrl.cond)
      itoa_pkg::COND_NEVER:     taken = 1'b0;
      itoa_pkg::COND_ALWAYS:    taken = 1'b1;
      itoa_pkg::COND_NO_ACCEPT: taken = !stat_i.accept;
      itoa_pkg::COND_CNT_NZ:    taken = stat_i.dp.cnt_nz;
      itoa_pkg::COND_QUOT_NZ:   taken = stat_i.dp.quot_nz;
      itoa_pkg::COND_OUT_BUSY:  taken = stat_i.out_busy;
      itoa_pkg::COND_SP_NZ:     taken = stat_i.dp.sp_nz;
      default:                  taken = 1'b1;
    endcase
    upc_d = taken ? ctrl.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= itoa_pkg::STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

`default_nettype wire

// File: design/itoa_dp.sv
// Datapath: operand load, one-bit-per-cycle restoring divider and character stack.
`default_nettype none

module itoa_dp #(
  parameter int unsigned VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire itoa_pkg::ctrl_t                      ctrl_i,
  input  wire logic                                 load_i,
  input  wire logic signed [VALUE_WIDTH-1:0]        value_i,
  input  wire logic        [itoa_pkg::BASE_W-1:0]   base_i,
  output logic             [itoa_pkg::CHAR_W-1:0]   rd_data_o,
  output itoa_pkg::dp_stat_t                        stat_o
);

  localparam int unsigned DEPTH = VALUE_WIDTH + 1;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned SP_W  = $clog2(DEPTH + 1);
  localparam int unsigned CNT_W = $clog2(VALUE_WIDTH);

  logic [VALUE_WIDTH-1:0]          quot_q, quot_d;
  logic [itoa_pkg::REM_W-1:0]      rem_q, rem_d;
  logic [itoa_pkg::BASE_W-1:0]     base_q, base_d;
  logic                            neg_q, neg_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [SP_W-1:0]                 sp_q, sp_d;

  logic [VALUE_WIDTH-1:0]          value_u;
  logic [itoa_pkg::BASE_W-1:0]     base_sat;
  logic                            is_neg;
  logic [itoa_pkg::REM_W:0]        trial;
  logic                            ge;
  logic                            wr_en;
  logic [itoa_pkg::CHAR_W-1:0]     wr_data;
  logic [SP_W-1:0]                 sp_dec;

  assign value_u = $unsigned(value_i);
  assign trial   = {rem_q, quot_q[VALUE_WIDTH-1]};
  assign ge      = trial >= {1'b0, base_q};
  assign sp_dec  = sp_q - 1'b1;

  always_comb begin
    priority if (base_i < itoa_pkg::BASE_MIN) begin
      base_sat = itoa_pkg::BASE_MIN;
    end else if (base_i > itoa_pkg::BASE_MAX) begin
      base_sat = itoa_pkg::BASE_MAX;
    end else begin
      base_sat = base_i;
    end
  end

  assign is_neg = value_u[VALUE_WIDTH-1] && (base_sat == itoa_pkg::DEC_BASE);

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    base_d = base_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    sp_d   = sp_q;
    if (load_i) begin
      quot_d = is_neg ? ({VALUE_WIDTH{1'b0}} - value_u) : value_u;
      base_d = base_sat;
      neg_d  = is_neg;
      sp_d   = '0;
    end
    if (ctrl_i.div_init) begin
      rem_d = '0;
      cnt_d = CNT_W'(VALUE_WIDTH - 1);
    end
    if (ctrl_i.div_step) begin
      // shift in one quotient bit, keep the partial remainder below the base
      quot_d = {quot_q[VALUE_WIDTH-2:0], ge};
      rem_d  = ge ? itoa_pkg::REM_W'(trial - {1'b0, base_q})
                  : trial[itoa_pkg::REM_W-1:0];
      cnt_d  = cnt_q - 1'b1;
    end
    if (wr_en) begin
      sp_d = sp_q + 1'b1;
    end
    if (ctrl_i.pop_rd) begin
      sp_d = sp_dec;
    end
  end

  assign wr_en   = ctrl_i.push_digit || (ctrl_i.push_minus && neg_q);
  assign wr_data = ctrl_i.push_minus ? itoa_pkg::CH_MINUS : itoa_pkg::digit_char(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      sp_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      sp_q  <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    base_q <= base_d;
    neg_q  <= neg_d;
  end

  itoa_ram #(
    .WIDTH (itoa_pkg::CHAR_W),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (sp_q[AW-1:0]),
    .wdata_i (wr_data),
    .re_i    (ctrl_i.pop_rd),
    .raddr_i (sp_dec[AW-1:0]),
    .rdata_o (rd_data_o)
  );

  assign stat_o.cnt_nz  = (cnt_q != '0);
  assign stat_o.quot_nz = (quot_q != '0);
  assign stat_o.sp_nz   = (sp_q != '0);

  a_sp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(DEPTH))
    else $error("stack pointer beyond stack depth");

  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> sp_q < SP_W'(DEPTH))
    else $error("push into a full stack");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.pop_rd |-> sp_q != '0)
    else $error("pop from an empty stack");

endmodule

`default_nettype wire

// File: design/integer_to_ascii_radix.sv
// Top level: integer to ASCII text in radix 2..36, one character per output item.
//
//  channel | direction | signals                               | handshake
//  --------+-----------+---------------------------------------+-----------------------
//  in      | in        | value_i[VALUE_WIDTH-1:0], base_i[5:0] | in_valid_i / in_stall_o
//  out     | out       | character_o[7:0], last_o              | out_valid_o / out_stall_i
//
//  One item at a time. Each digit is divided out in the shared one-bit-per-cycle
//  divider (init, then one step per quotient bit) and pushed; each character is then
//  popped from the stack and emitted, with load, sign and return steps per item.
//  Reset clears the step counter and stack pointer; no clearing pass is needed.
//  A stalled output holds the sequencer in its wait step; no character is dropped.
`default_nettype none

module integer_to_ascii_radix #(
  parameter int unsigned VALUE_WIDTH = itoa_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [VALUE_WIDTH-1:0]       value_i,
  input  wire logic        [itoa_pkg::BASE_W-1:0]  base_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic             [itoa_pkg::CHAR_W-1:0]  character_o,
  output logic                                     last_o
);

  itoa_pkg::ctrl_t             ctrl;
  itoa_pkg::dp_stat_t          dp_stat;
  itoa_pkg::seq_stat_t         seq_stat;
  logic [itoa_pkg::CHAR_W-1:0] rd_data;
  logic                        in_accept;
  logic                        out_busy;

  logic                        out_valid_q, out_valid_d;
  logic [itoa_pkg::CHAR_W-1:0] char_q;
  logic                        last_q;

  assign in_stall_o = !ctrl.in_ready;
  assign in_accept  = in_valid_i && ctrl.in_ready;
  assign out_busy   = out_valid_q && out_stall_i;

  assign seq_stat.accept   = in_accept;
  assign seq_stat.out_busy = out_busy;
  assign seq_stat.dp       = dp_stat;

  itoa_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (seq_stat),
    .ctrl_o (ctrl)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .load_i    (ctrl.load && in_accept),
    .value_i   (value_i),
    .base_i    (base_i),
    .rd_data_o (rd_data),
    .stat_o    (dp_stat)
  );

  // Output register: drop the valid once taken, load on emit
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (ctrl.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      char_q <= rd_data;
      last_q <= !dp_stat.sp_nz;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  a_emit_into_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> !out_valid_q)
    else $error("character emitted over an undelivered one");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled item dropped");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(character_o) && $stable(last_o))
    else $error("stalled item changed");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for integer_to_ascii_radix: random and directed items against a text predictor.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned VW          = 32;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEMS_PER_PHASE = 25;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } text_char_t;

  class text_scoreboard;
    text_char_t chars_due[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // Build the expected text of one accepted item, most significant character first.
    function void note_input(logic [VW-1:0] value, logic [itoa_pkg::BASE_W-1:0] base);
      logic [VW-1:0] mag;
      int unsigned   radix;
      int unsigned   d;
      logic          neg;
      logic [itoa_pkg::CHAR_W-1:0] digits[$];
      text_char_t    tc;
      radix = 32'(base);
      if (radix < itoa_pkg::BASE_MIN) radix = 32'(itoa_pkg::BASE_MIN);
      if (radix > itoa_pkg::BASE_MAX) radix = 32'(itoa_pkg::BASE_MAX);
      mag = value;
      neg = (radix == itoa_pkg::DEC_BASE) && value[VW-1];
      if (neg) mag = -value;
      if (mag == '0) digits.push_front(itoa_pkg::CH_ZERO);
      while (mag != '0) begin
        d = mag % radix;
        if (d < itoa_pkg::DEC_BASE) digits.push_front(itoa_pkg::CH_ZERO + itoa_pkg::CHAR_W'(d));
        else digits.push_front(itoa_pkg::CH_LOWA + itoa_pkg::CHAR_W'(d - itoa_pkg::DEC_BASE));
        mag = mag / radix;
      end
      if (neg) digits.push_front(itoa_pkg::CH_MINUS);
      foreach (digits[i]) begin
        tc.ch   = digits[i];
        tc.last = (i == digits.size() - 1);
        chars_due.push_back(tc);
      end
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
    endfunction

    function void check_result(logic [itoa_pkg::CHAR_W-1:0] ch, logic last);
      text_char_t want;
      if (chars_due.size() == 0) begin
        report($sformatf("unexpected item: character %h last %b", ch, last));
        return;
      end
      want = chars_due.pop_front();
      if (ch !== want.ch)
        report($sformatf("character mismatch: expected %h got %h", want.ch, ch));
      if (last !== want.last)
        report($sformatf("last mismatch on %h: expected %b got %b", want.ch, want.last, last));
    endfunction

    function int unsigned pending();
      return chars_due.size();
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [VW-1:0]          value_i = '0;
  logic [itoa_pkg::BASE_W-1:0]   base_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [itoa_pkg::CHAR_W-1:0]   character_o;
  logic                          last_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  text_scoreboard texts = new();

  integer_to_ascii_radix #(.VALUE_WIDTH(VW)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .base_i      (base_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) texts.check_result(character_o, last_o);
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  // Offer one item, hold it until accepted, then note it for prediction.
  task automatic send_number(logic [VW-1:0] value, logic [itoa_pkg::BASE_W-1:0] base);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= value;
    base_i     <= base;
    do @(posedge clk_i); while (in_stall_o);
    texts.note_input(value, base);
  endtask

  task automatic drain_texts();
    in_valid_i <= 1'b0;
    while (texts.pending() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_number();
    logic [VW-1:0]               value;
    logic [itoa_pkg::BASE_W-1:0] base;
    case ($urandom_range(0, 3))
      0: value = VW'($urandom);
      1: value = VW'($urandom_range(0, 999));
      2: value = VW'(-$urandom_range(1, 1000));
      default: value = (VW'(1) << $urandom_range(0, VW - 1)) - VW'($urandom_range(0, 1));
    endcase
    case ($urandom_range(0, 2))
      0: base = itoa_pkg::BASE_W'($urandom_range(0, 63));
      1: base = itoa_pkg::DEC_BASE;
      default: base = itoa_pkg::BASE_W'($urandom_range(itoa_pkg::BASE_MIN, itoa_pkg::BASE_MAX));
    endcase
    send_number(value, base);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, sign handling, extremes, digit letters, base saturation.
    send_number(32'd0, 6'd10);
    send_number(32'd0, 6'd2);
    send_number(-32'sd1, 6'd10);
    send_number(-32'sd1, 6'd2);
    send_number(-32'sd1, 6'd16);
    send_number(32'h8000_0000, 6'd10);
    send_number(32'h8000_0000, 6'd16);
    send_number(32'h7fff_ffff, 6'd10);
    send_number(32'h7fff_ffff, 6'd36);
    send_number(32'd35, 6'd36);
    send_number(32'd36, 6'd36);
    send_number(32'd10, 6'd16);
    send_number(-32'sd42, 6'd10);
    send_number(-32'sd7, 6'd9);
    send_number(32'd1, 6'd0);
    send_number(32'd5, 6'd1);
    send_number(32'd100, 6'd63);
    send_number(32'd12345, 6'd37);
    send_number(32'd255, 6'd8);
    send_number(32'd7, 6'd3);
    send_number(32'd9, 6'd10);

    for (int phase = 0; phase < 4; phase++) begin
      // Hold the sender until every character so far has come back.
      drain_texts();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_number();
    end

    drain_texts();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (texts.errors == 0 && texts.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
design/itoa_pkg.sv
design/itoa_ram.sv
design/itoa_seq.sv
design/itoa_dp.sv
design/integer_to_ascii_radix.sv
tb/tb.sv
